[rtl/core/matrix3x3_inverse_macros.svh]
// Assertion macros used by the matrix inverse top level.
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH
`ifndef ASSERT_OFF
`define M3INV_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("matrix inverse check failed");
`define M3INV_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("matrix inverse check failed");
`else
`define M3INV_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define M3INV_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/core/m3inv_pkg.sv]
// Types, widths and cofactor tables shared by the matrix inverse modules.
`default_nettype none
package m3inv_pkg;
    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int PART_W    = COF_W;
    localparam int TERM_W    = ELEM_W + COF_W;
    localparam int DET_W     = TERM_W + 2;
    localparam int DMAG_W    = 96;
    localparam int QUO_W     = ELEM_W + 1;
    localparam int NUM_W     = PROD_W + 2 * FRAC_BITS;
    localparam int WIDE_W    = (NUM_W > DMAG_W + QUO_W + 1) ? NUM_W : DMAG_W + QUO_W + 1;
    localparam int NUM_ELEM  = 9;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [DMAG_W-1:0]        dmag_t;
    typedef logic [3:0]               idx_t;

    // Determinant summary handed to every divider lane.
    typedef struct packed {
        logic  neg;
        logic  zero;
        dmag_t mag;
    } det_info_t;

    // What one lane reports to the merging stage.
    typedef struct packed {
        elem_t res;
        logic  sat;
        logic  sing;
    } lane_res_t;

    // Cofactor i is m[X]*m[Y] - m[Z]*m[W], already transposed (adjugate order).
    localparam idx_t COF_X [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam idx_t COF_Y [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam idx_t COF_Z [NUM_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_t COF_W_ [NUM_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
endpackage
`default_nettype wire

[rtl/core/m3inv_cof.sv]
// Cofactor stage: nine 2x2 determinants, two pipeline stages.
`default_nettype none
module m3inv_cof (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  m3inv_pkg::elem_t    m [m3inv_pkg::NUM_ELEM],
    output logic                out_valid,
    input  logic                out_ready,
    output m3inv_pkg::cof_t     cof [m3inv_pkg::NUM_ELEM],
    output m3inv_pkg::elem_t    row0 [3]
);
    localparam int NSTG = 2;

    logic [NSTG-1:0]  v_reg;
    logic [NSTG-1:0]  en;
    m3inv_pkg::prod_t p_reg [m3inv_pkg::NUM_ELEM];
    m3inv_pkg::prod_t q_reg [m3inv_pkg::NUM_ELEM];
    m3inv_pkg::cof_t  cof_reg [m3inv_pkg::NUM_ELEM];
    m3inv_pkg::elem_t row_reg [NSTG][3];

    // A stage moves when any stage at or after it is empty or the sink takes.
    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            en[i] = out_ready || (((~v_reg) >> i) != '0);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    // Products, then differences.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < m3inv_pkg::NUM_ELEM; i++)
            begin
                p_reg[i] <= m[m3inv_pkg::COF_X[i]] * m[m3inv_pkg::COF_Y[i]];
                q_reg[i] <= m[m3inv_pkg::COF_Z[i]] * m[m3inv_pkg::COF_W_[i]];
            end
            for (int k = 0; k < 3; k++)
            begin
                row_reg[0][k] <= m[k];
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < m3inv_pkg::NUM_ELEM; i++)
            begin
                cof_reg[i] <= m3inv_pkg::COF_W'(p_reg[i]) - m3inv_pkg::COF_W'(q_reg[i]);
            end
            row_reg[1] <= row_reg[0];
        end
    end

    assign cof  = cof_reg;
    assign row0 = row_reg[NSTG-1];
endmodule
`default_nettype wire

[rtl/core/m3inv_det.sv]
// Determinant along the first row, split multiplies, four pipeline stages.
`default_nettype none
module m3inv_det (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  m3inv_pkg::cof_t       cof_in [m3inv_pkg::NUM_ELEM],
    input  m3inv_pkg::elem_t      row0 [3],
    output logic                  out_valid,
    input  logic                  out_ready,
    output m3inv_pkg::cof_t       cof_out [m3inv_pkg::NUM_ELEM],
    output m3inv_pkg::det_info_t  det
);
    localparam int NSTG = 4;
    localparam int HALF = m3inv_pkg::ELEM_W;

    logic [NSTG-1:0]       v_reg;
    logic [NSTG-1:0]       en;
    m3inv_pkg::cof_t       cof_reg [NSTG][m3inv_pkg::NUM_ELEM];
    m3inv_pkg::part_t      pl_reg [3];
    m3inv_pkg::part_t      ph_reg [3];
    m3inv_pkg::term_t      term_reg [3];
    m3inv_pkg::det_t       det_reg;
    m3inv_pkg::det_info_t  info_reg;

    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            en[i] = out_ready || (((~v_reg) >> i) != '0);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Each row-0 term is split into low and high cofactor halves.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pl_reg[k] <= row0[k] * $signed({1'b0, cof_in[3*k][HALF-1:0]});
                ph_reg[k] <= row0[k] * $signed(cof_in[3*k][m3inv_pkg::COF_W-1:HALF]);
            end
            cof_reg[0] <= cof_in;
        end
        if (en[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                term_reg[k] <= (m3inv_pkg::TERM_W'(ph_reg[k]) <<< HALF)
                             + m3inv_pkg::TERM_W'(pl_reg[k]);
            end
            cof_reg[1] <= cof_reg[0];
        end
        if (en[2])
        begin
            det_reg <= m3inv_pkg::DET_W'(term_reg[0]) + m3inv_pkg::DET_W'(term_reg[1])
                     + m3inv_pkg::DET_W'(term_reg[2]);
            cof_reg[2] <= cof_reg[1];
        end
        if (en[3])
        begin
            info_reg.neg  <= det_reg[m3inv_pkg::DET_W-1];
            info_reg.zero <= (det_reg == '0);
            info_reg.mag  <= det_reg[m3inv_pkg::DET_W-1]
                           ? m3inv_pkg::DMAG_W'(-det_reg)
                           : m3inv_pkg::DMAG_W'(det_reg);
            cof_reg[3] <= cof_reg[2];
        end
    end

    assign cof_out = cof_reg[NSTG-1];
    assign det     = info_reg;
endmodule
`default_nettype wire

[rtl/core/m3inv_lane.sv]
// One divider lane: cofactor divided by the determinant, one quotient bit per stage.
`default_nettype none
module m3inv_lane (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  m3inv_pkg::cof_t       cof,
    input  m3inv_pkg::det_info_t  det,
    output logic                  out_valid,
    input  logic                  out_ready,
    output m3inv_pkg::lane_res_t  res
);
    localparam int QW   = m3inv_pkg::QUO_W;
    localparam int WW   = m3inv_pkg::WIDE_W;
    localparam int EW   = m3inv_pkg::ELEM_W;
    localparam int NSTG = QW + 2;

    logic [NSTG-1:0]       v_reg;
    logic [NSTG-1:0]       en;
    logic [WW-1:0]         rem_reg [QW+1];
    m3inv_pkg::dmag_t      d_reg [QW+1];
    logic [QW-1:0]         q_reg [QW+1];
    logic                  neg_reg [QW+1];
    logic                  ovf_reg [QW+1];
    logic                  zero_reg [QW+1];
    logic [WW-1:0]         rem_next [QW+1];
    logic [QW-1:0]         q_next [QW+1];
    logic                  cof_neg;
    logic [m3inv_pkg::PROD_W-1:0] cof_mag;
    logic [WW-1:0]         num_w;
    logic [WW-1:0]         dlim_w;
    logic [WW-1:0]         dsh;
    logic                  take;
    logic [QW-1:0]         lim;
    logic [EW-1:0]         mag;
    logic                  clamp;
    m3inv_pkg::lane_res_t  res_next;
    m3inv_pkg::lane_res_t  res_reg;

    always_comb
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            en[i] = out_ready || (((~v_reg) >> i) != '0);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // Entry: magnitude of the scaled cofactor and the overflow check on the top bits.
    always_comb
    begin
        cof_neg = cof[m3inv_pkg::COF_W-1];
        cof_mag = cof_neg ? m3inv_pkg::PROD_W'(-cof) : cof[m3inv_pkg::PROD_W-1:0];
        num_w   = WW'({cof_mag, {(2 * m3inv_pkg::FRAC_BITS){1'b0}}});
        dlim_w  = WW'(det.mag) << QW;
    end

    // Restoring steps, one quotient bit per stage from the top.
    always_comb
    begin
        rem_next[0] = num_w;
        q_next[0]   = '0;
        for (int s = 1; s <= QW; s++)
        begin
            dsh         = WW'(d_reg[s-1]) << (QW - s);
            take        = (rem_reg[s-1] >= dsh);
            rem_next[s] = take ? rem_reg[s-1] - dsh : rem_reg[s-1];
            q_next[s]   = q_reg[s-1] | (QW'(take) << (QW - s));
        end
    end

    // Exit: clamp to the element range and restore the sign; a zero determinant gives zero.
    always_comb
    begin
        lim   = neg_reg[QW] ? (QW'(1) << (EW - 1)) : ((QW'(1) << (EW - 1)) - QW'(1));
        clamp = ovf_reg[QW] || (q_reg[QW] > lim);
        mag   = clamp ? lim[EW-1:0] : q_reg[QW][EW-1:0];
        res_next.sing = zero_reg[QW];
        res_next.sat  = clamp && !zero_reg[QW];
        if (zero_reg[QW])
        begin
            res_next.res = '0;
        end
        else
        begin
            res_next.res = neg_reg[QW] ? -mag : mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            d_reg[0]    <= det.mag;
            neg_reg[0]  <= cof_neg ^ det.neg;
            ovf_reg[0]  <= (num_w >= dlim_w);
            zero_reg[0] <= det.zero;
        end
        for (int s = 1; s <= QW; s++)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= rem_next[s];
                q_reg[s]    <= q_next[s];
                d_reg[s]    <= d_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
        if (en[NSTG-1])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;
endmodule
`default_nettype wire

[rtl/core/matrix3x3_inverse.sv]
// Top level of the 3x3 fixed-point matrix inverse.
//
// Usage: one item on the input channel (in_valid/in_ready) is a row-major
// 3x3 matrix m00..m22 of signed Q16.16 elements. One item on the output
// channel (out_valid/out_ready) is the inverse r00..r22 with the flags
// singular (zero determinant, all elements zero) and saturated (at least
// one element clamped to the Q16.16 range).
// Pipeline: 42 register stages from input to output: two for the cofactors,
// four for the determinant, 35 in each divider lane (entry,
// one quotient bit per stage for 33 bits, clamp) and one merging register.
// Throughput: one item per cycle when not stalled; nine divider lanes run
// side by side, one per element, and the restoring divider sets the depth.
// Reset clears only the valid bits; the pipeline comes up empty.
// When the receiver stalls, stages fill up behind the output register,
// and in_ready falls only once every stage holds an item.
`default_nettype none
`include "matrix3x3_inverse_macros.svh"
module matrix3x3_inverse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  m3inv_pkg::elem_t m00,
    input  m3inv_pkg::elem_t m01,
    input  m3inv_pkg::elem_t m02,
    input  m3inv_pkg::elem_t m10,
    input  m3inv_pkg::elem_t m11,
    input  m3inv_pkg::elem_t m12,
    input  m3inv_pkg::elem_t m20,
    input  m3inv_pkg::elem_t m21,
    input  m3inv_pkg::elem_t m22,
    output logic             out_valid,
    input  logic             out_ready,
    output m3inv_pkg::elem_t r00,
    output m3inv_pkg::elem_t r01,
    output m3inv_pkg::elem_t r02,
    output m3inv_pkg::elem_t r10,
    output m3inv_pkg::elem_t r11,
    output m3inv_pkg::elem_t r12,
    output m3inv_pkg::elem_t r20,
    output m3inv_pkg::elem_t r21,
    output m3inv_pkg::elem_t r22,
    output logic             singular,
    output logic             saturated
);
    localparam int N = m3inv_pkg::NUM_ELEM;

    m3inv_pkg::elem_t      m_arr [N];
    m3inv_pkg::cof_t       cof_c [N];
    m3inv_pkg::elem_t      row0 [3];
    logic                  cof_valid;
    logic                  det_ready;
    logic                  det_valid;
    m3inv_pkg::cof_t       cof_d [N];
    m3inv_pkg::det_info_t  det;
    logic [N-1:0]          lane_ready;
    logic [N-1:0]          lane_valid;
    m3inv_pkg::lane_res_t  lane_res [N];
    logic                  merge_en;
    logic                  out_valid_reg;
    m3inv_pkg::elem_t      r_reg [N];
    logic                  singular_reg;
    logic                  saturated_reg;
    logic [N-1:0]          sat_vec;
    logic [N-1:0]          sing_vec;

    assign m_arr = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

    m3inv_cof u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .m         (m_arr),
        .out_valid (cof_valid),
        .out_ready (det_ready),
        .cof       (cof_c),
        .row0      (row0)
    );

    m3inv_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .in_ready  (det_ready),
        .cof_in    (cof_c),
        .row0      (row0),
        .out_valid (det_valid),
        .out_ready (&lane_ready),
        .cof_out   (cof_d),
        .det       (det)
    );

    // One divider lane per element; all lanes move in lockstep.
    for (genvar i = 0; i < N; i++)
    begin : g_lane
        m3inv_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (det_valid),
            .in_ready  (lane_ready[i]),
            .cof       (cof_d[i]),
            .det       (det),
            .out_valid (lane_valid[i]),
            .out_ready (merge_en),
            .res       (lane_res[i])
        );
    end

    // Merge the lane flags into the item's flags.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            sat_vec[i]  = lane_res[i].sat;
            sing_vec[i] = lane_res[i].sing;
        end
    end

    assign merge_en = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (merge_en)
        begin
            out_valid_reg <= &lane_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (merge_en && (&lane_valid))
        begin
            for (int i = 0; i < N; i++)
            begin
                r_reg[i] <= lane_res[i].res;
            end
            singular_reg  <= |sing_vec;
            saturated_reg <= (|sat_vec) && !(|sing_vec);
        end
    end

    assign out_valid = out_valid_reg;
    assign r00 = r_reg[0];
    assign r01 = r_reg[1];
    assign r02 = r_reg[2];
    assign r10 = r_reg[3];
    assign r11 = r_reg[4];
    assign r12 = r_reg[5];
    assign r20 = r_reg[6];
    assign r21 = r_reg[7];
    assign r22 = r_reg[8];
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

    `M3INV_ASSERT_IMPLY(a_sing_not_sat, clk, rst_n, out_valid && singular, !saturated)
    `M3INV_ASSERT_IMPLY(a_sing_zero, clk, rst_n, out_valid && singular, (r00 == '0) && (r11 == '0) && (r22 == '0))
    `M3INV_ASSERT_IMPLY(a_lane_lockstep, clk, rst_n, lane_valid != '0, lane_valid == '1)
    `M3INV_ASSERT_NEXT(a_merge_load, clk, rst_n, merge_en && (lane_valid == '1), out_valid)
endmodule
`default_nettype wire

[verif/tb_matrix3x3_inverse.sv]
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
`default_nettype none
module tb_matrix3x3_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM   = 1550;
    localparam int N_QUIET    = 150;
    localparam int DRAIN_CYC  = 80;
    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    typedef logic [8:0][31:0] mat_t;

    typedef struct packed {
        mat_t r;
        logic sing;
        logic sat;
    } inv_t;

    typedef struct packed {
        mat_t m;
        bit   typed;
        inv_t want;
    } row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    m3inv_pkg::elem_t m [9];
    logic     out_valid;
    logic     out_ready;
    m3inv_pkg::elem_t r [9];
    logic     singular;
    logic     saturated;

    inv_t     inverse_q [$];
    int       mismatches;
    int       checked;
    int       n_sing;
    int       n_sat;
    bit       quiet;

    matrix3x3_inverse dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .m00(m[0]), .m01(m[1]), .m02(m[2]),
        .m10(m[3]), .m11(m[4]), .m12(m[5]),
        .m20(m[6]), .m21(m[7]), .m22(m[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .r00(r[0]), .r01(r[1]), .r02(r[2]),
        .r10(r[3]), .r11(r[4]), .r12(r[5]),
        .r20(r[6]), .r21(r[7]), .r22(r[8]),
        .singular(singular), .saturated(saturated)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Exact adjugate over determinant, truncated toward zero, then clamped; a zero determinant gives the singular flag.
    function automatic inv_t invert(mat_t a);
        logic signed [127:0] e [9];
        logic signed [127:0] adj [9];
        logic signed [127:0] det;
        logic [127:0] dmag;
        logic [127:0] nmag;
        logic [127:0] q;
        logic [127:0] lim;
        bit neg;
        inv_t res;
        for (int i = 0; i < 9; i++)
            e[i] = {{96{a[i][31]}}, a[i]};
        adj[0] = e[4] * e[8] - e[5] * e[7];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[2] * e[3] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[4] * e[6];
        adj[7] = e[1] * e[6] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        res = '0;
        if (det == 0)
        begin
            res.sing = 1'b1;
            return res;
        end
        dmag = det < 0 ? -det : det;
        for (int i = 0; i < 9; i++)
        begin
            nmag = (adj[i] < 0 ? -adj[i] : adj[i]) << (2 * m3inv_pkg::FRAC_BITS);
            q = nmag / dmag;
            neg = ((adj[i] < 0) != (det < 0)) && (q != 0);
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (q > lim)
            begin
                q = lim;
                res.sat = 1'b1;
            end
            res.r[i] = neg ? -q[31:0] : q[31:0];
        end
        return res;
    endfunction

    function automatic mat_t diag(logic [31:0] v);
        mat_t a;
        a = '0;
        a[0] = v;
        a[4] = v;
        a[8] = v;
        return a;
    endfunction

    // One matrix per call, with an optional idle burst in front.
    task automatic send_matrix(mat_t a, bit typed, inv_t want);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
            m[i] <= a[i];
        do
            @(posedge clk);
        while (!in_ready);
        inverse_q.push_back(typed ? want : invert(a));
        @(negedge clk);
    endtask

    // Random matrix drawn from one of several shapes.
    function automatic mat_t random_matrix();
        mat_t a;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
        begin
            case (kind)
                0, 1:    a[i] = $urandom;
                2, 3, 4: a[i] = $signed($urandom_range(0, 16)) - 8 << m3inv_pkg::FRAC_BITS;
                5, 6:    a[i] = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                7:       a[i] = $signed($urandom_range(0, 6)) - 3;
                default: a[i] = (i % 4 == 0) ? $urandom_range(1 << 14, 1 << 22)
                                             : $signed($urandom_range(0, 512)) - 256;
            endcase
        end
        // Duplicate a row now and then to make the matrix singular.
        if ($urandom_range(0, 11) == 0)
        begin
            a[3] = a[0];
            a[4] = a[1];
            a[5] = a[2];
        end
        return a;
    endfunction

    // Receiver: ready stalls in random bursts until the quiet tail.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    // Compare each accepted result with the oldest expected inverse.
    always @(posedge clk)
    begin
        inv_t want;
        inv_t got;
        if (rst_n && out_valid && out_ready)
        begin
            for (int i = 0; i < 9; i++)
                got.r[i] = r[i];
            got.sing = singular;
            got.sat = saturated;
            if (inverse_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no item pending: %h", got);
            end
            else
            begin
                want = inverse_q.pop_front();
                checked++;
                n_sing += got.sing;
                n_sat += got.sat;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        for (int i = 0; i < 9; i++)
                            if (got.r[i] !== want.r[i])
                                $display("ERROR: r%0d%0d expected %h got %h",
                                         i / 3, i % 3, want.r[i], got.r[i]);
                        $display("ERROR: flags expected sing=%b sat=%b got sing=%b sat=%b",
                                 want.sing, want.sat, got.sing, got.sat);
                    end
                end
            end
        end
    end

    // Stimulus: directed table first, then random matrices.
    initial
    begin
        row_t rows [$];
        row_t rw;
        mat_t a;
        int wait_cyc;
        in_valid = 1'b0;
        for (int i = 0; i < 9; i++)
            m[i] = '0;
        quiet = 1'b0;
        mismatches = 0;
        checked = 0;
        n_sing = 0;
        n_sat = 0;

        // Identity maps to identity.
        rw = '0; rw.m = diag(ONE); rw.typed = 1; rw.want.r = diag(ONE); rows.push_back(rw);
        // The zero matrix and constant matrices are singular.
        rw = '0; rw.typed = 1; rw.want.sing = 1; rows.push_back(rw);
        rw = '0; rw.m = {9{POS_MAX}}; rw.typed = 1; rw.want.sing = 1; rows.push_back(rw);
        rw = '0; rw.m = {9{NEG_MAX}}; rw.typed = 1; rw.want.sing = 1; rows.push_back(rw);
        // Diagonal of two gives a diagonal of one half.
        rw = '0; rw.m = diag(32'h0002_0000); rw.typed = 1;
        rw.want.r = diag(32'h0000_8000); rows.push_back(rw);
        // Smallest positive and negative raw diagonals clamp both ways.
        rw = '0; rw.m = diag(32'd1); rw.typed = 1; rw.want.sat = 1;
        rw.want.r = diag(POS_MAX); rows.push_back(rw);
        rw = '0; rw.m = diag(32'hFFFF_FFFF); rw.typed = 1; rw.want.sat = 1;
        rw.want.r = diag(NEG_MAX); rows.push_back(rw);
        // Large diagonals, tiny determinant off-diagonal cases, mixed extremes.
        rw = '0; rw.m = diag(POS_MAX); rows.push_back(rw);
        rw = '0; rw.m = diag(NEG_MAX); rows.push_back(rw);
        rw = '0; rw.m = {NEG_MAX, POS_MAX, 32'd0, 32'd1, NEG_MAX, POS_MAX,
                         POS_MAX, 32'd0, NEG_MAX}; rows.push_back(rw);
        rw = '0; rw.m = {32'd0, 32'd0, ONE, 32'd0, ONE, 32'd0, ONE, 32'd0, 32'd0};
        rows.push_back(rw);
        rw = '0; rw.m = {32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1};
        rows.push_back(rw);
        rw = '0; rw.m = {32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
                         32'h8765_4321, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_FFFF,
                         32'hFFFF_0000}; rows.push_back(rw);

        @(posedge rst_n);
        @(negedge clk);
        foreach (rows[i])
            send_matrix(rows[i].m, rows[i].typed, rows[i].want);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - N_QUIET)
                quiet = 1'b1;
            a = random_matrix();
            send_matrix(a, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain, then allow the pipeline depth for stray results.
        wait_cyc = 0;
        while (inverse_q.size() != 0 && wait_cyc < 100000)
        begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC) @(posedge clk);
        if (inverse_q.size() != 0)
            mismatches += inverse_q.size();
        $display("Checked %0d inverses: %0d singular, %0d with clamped elements.",
                 checked, n_sing, n_sat);
        $display("Mismatch count: %0d", mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2ms;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
